/* rtl/gbs_pkg.sv */
// Shared types, constants and elaboration-time helpers for the blobby
// density grid splat core. No dependencies.
`default_nettype none

package gbs_pkg;

  // Default sizes.
  localparam int GRID_SIDE_DEF      = 64;
  localparam int EXP_TABLE_BITS_DEF = 10;

  // Field widths.
  localparam int CENTRE_W   = 22;
  localparam int RADIUS_W   = 16;
  localparam int VOXEL_W    = 6;
  localparam int BLOB_W     = 16;
  localparam int HW_W       = 6;
  localparam int EXT_W      = 7;
  localparam int IDX_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VALUE_W    = 32;
  localparam int FRAC_W     = 12;
  localparam int WIN_W      = 12;
  localparam int DIST_W     = 24;
  localparam int D2_W       = 48;
  localparam int R2_W       = 32;
  localparam int QUOT_W     = 29;

  // Reset values of the configuration registers.
  localparam logic [BLOB_W-1:0] BLOB_RESET = 16'hD800;  // -2.5 in Q3.12
  localparam logic [HW_W-1:0]   HW_RESET   = 6'd10;
  localparam logic [EXT_W-1:0]  EXT_RESET  = 7'd64;

  // Half a voxel in Q.12.
  localparam logic [CENTRE_W-1:0] HALF_VOXEL = 22'd2048;

  // log2(e) in Q30.
  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_SPLAT = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOB       = 3'd0,
    CFG_HALF_WIDTH = 3'd1,
    CFG_EXT_X      = 3'd2,
    CFG_EXT_Y      = 3'd3,
    CFG_EXT_Z      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [CENTRE_W-1:0] centre_x;
    logic [CENTRE_W-1:0] centre_y;
    logic [CENTRE_W-1:0] centre_z;
    logic [RADIUS_W-1:0] atom_radius;
    logic [VOXEL_W-1:0]  voxel_x;
    logic [VOXEL_W-1:0]  voxel_y;
    logic [VOXEL_W-1:0]  voxel_z;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] field_value;
    logic               index_outside;
    logic               saturated;
  } out_rsp_t;

  // Request from the sequencer to the density term unit.
  typedef struct packed {
    logic              start;
    logic [D2_W-1:0]   d2;
    logic [R2_W-1:0]   r2;
    logic [BLOB_W-1:0] t;
  } term_req_t;

  typedef struct packed {
    logic               done;
    logic               skip;
    logic [VALUE_W-1:0] term;
  } term_rsp_t;

  // Integer square root, used only while building the exp table.
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    x = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Entry k of the 2^(k/2^bits) table in Q30, as a product of square roots.
  function automatic logic [31:0] exp_tbl_entry(int k, int bits);
    logic [63:0] roots [15];
    logic [63:0] acc;
    roots[0] = 64'h8000_0000;
    for (int j = 1; j < 15; j++) begin
      roots[j] = (j <= bits) ? isqrt64(roots[j-1] << 30) : 64'd0;
    end
    acc = 64'h4000_0000;
    for (int b = 0; b < 14; b++) begin
      if (b < bits && ((k >> b) & 1) == 1) begin
        acc = (acc * roots[bits-b] + 64'h2000_0000) >> 30;
      end
    end
    return acc[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/gbs_grid_mem.sv */
// Density grid storage: one write port and one read port with registered
// read data. Depends on nothing.
`default_nettype none

module gbs_grid_mem #(
  parameter int Depth = 262144,
  parameter int AddrW = 18
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [31:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [31:0]      rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data appear in the cycle after re_i.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/gbs_term.sv */
// Density term unit: bit-serial quotient d2/r2, blobbyness scaling and a
// table-interpolated exp. Depends on gbs_pkg.
`default_nettype none

module gbs_term
  import gbs_pkg::*;
#(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire term_req_t req_i,
  output term_rsp_t      rsp_o
);

  localparam int TblN   = 1 << EXP_TABLE_BITS;
  localparam int ZFracW = 24;
  localparam int FracW  = ZFracW - EXP_TABLE_BITS;
  localparam int RemW   = D2_W + FRAC_W + 1;
  localparam int A24W   = 48;
  localparam int XW     = 29;
  localparam int XlW    = XW + 32;
  localparam int ZW     = 31;
  localparam int NW     = ZW - ZFracW;
  localparam int PmW    = VALUE_W + FracW;

  localparam logic signed [A24W-1:0] A24Limit = 48'sh1000_0000;
  localparam logic signed [XlW-1:0]  ZRound   = 61'sh2000_0000;
  localparam logic signed [30:0]     Q12One   = 31'sd4096;

  typedef logic [VALUE_W-1:0] tbl_t [TblN+1];

  function automatic tbl_t build_tbl();
    tbl_t t;
    for (int k = 0; k < TblN; k++) begin
      t[k] = exp_tbl_entry(k, EXP_TABLE_BITS);
    end
    t[TblN] = 32'h8000_0000;
    return t;
  endfunction

  localparam tbl_t ExpTbl = build_tbl();

  typedef enum logic [2:0] {
    T_IDLE, T_DIV, T_A24, T_CHK, T_Z, T_MUL, T_RND
  } tstate_e;

  tstate_e                  state_q;
  logic [RemW-1:0]          rem_q;
  logic [RemW-1:0]          dsh_q;
  logic [QUOT_W-1:0]        quo_q;
  logic [4:0]               cnt_q;
  logic [BLOB_W-1:0]        t_q;
  logic signed [A24W-1:0]   a24_q;
  logic signed [XlW-1:0]    xl_q;
  logic [VALUE_W-1:0]       lo_q;
  logic [VALUE_W-1:0]       hi_q;
  logic [FracW-1:0]         frac_q;
  logic signed [NW-1:0]     n_q;
  logic [PmW-1:0]           pm_q;
  logic                     done_q;
  logic                     skip_q;
  logic [VALUE_W-1:0]       term_q;

  logic                     over;
  logic                     ge;
  logic signed [A24W-1:0]   neg_a24;
  logic signed [XW-1:0]     x_s;
  logic signed [31:0]       l_s;
  logic signed [XlW-1:0]    z_full;
  logic signed [ZW-1:0]     z;
  logic [EXP_TABLE_BITS:0]  k_lo;
  logic [EXP_TABLE_BITS:0]  k_hi;
  logic [VALUE_W:0]         m;
  logic signed [7:0]        sh;
  logic [5:0]               amt;
  logic [63:0]              rounded;
  logic [VALUE_W-1:0]       term_d;

  // Quotient overflow: q would reach 2^29, far past the cutoff.
  assign over = {1'b0, req_i.d2, {FRAC_W{1'b0}}} >= {req_i.r2, {QUOT_W{1'b0}}};
  assign ge   = rem_q >= dsh_q;

  // Exponent argument and its base-2 split.
  assign neg_a24 = -a24_q;
  assign x_s     = neg_a24[XW-1:0];
  assign l_s     = $signed(LOG2E_Q30);
  assign z_full  = (xl_q + ZRound) >>> 30;
  assign z       = z_full[ZW-1:0];
  assign k_lo    = {1'b0, z[ZFracW-1:FracW]};
  assign k_hi    = k_lo + 1'b1;

  // Mantissa and final scaling by 2^n with round half up.
  assign m  = {1'b0, lo_q} + (VALUE_W+1)'(pm_q >> FracW);
  assign sh = 8'sd14 - {n_q[NW-1], n_q};
  always_comb begin
    amt     = 6'd1;
    rounded = '0;
    term_d  = '0;
    if (sh < 8'sd63) begin
      amt     = (sh < 8'sd1) ? 6'd1 : sh[5:0];
      rounded = ({31'b0, m} + (64'd1 << (amt - 6'd1))) >> amt;
      term_d  = rounded[VALUE_W-1:0];
    end
  end

  // Sequencer for one term.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
      skip_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (req_i.start) begin
            t_q <= req_i.t;
            if (over) begin
              done_q <= 1'b1;
              skip_q <= 1'b1;
            end else begin
              rem_q   <= {1'b0, req_i.d2, {FRAC_W{1'b0}}};
              dsh_q   <= {1'b0, req_i.r2, {(QUOT_W-1){1'b0}}};
              quo_q   <= '0;
              cnt_q   <= 5'(QUOT_W - 1);
              state_q <= T_DIV;
            end
          end
        end
        T_DIV: begin
          if (ge) rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[QUOT_W-2:0], ge};
          dsh_q <= dsh_q >> 1;
          if (cnt_q == 5'd0) state_q <= T_A24;
          else cnt_q <= cnt_q - 5'd1;
        end
        T_A24: begin
          a24_q   <= $signed({1'b0, t_q}) * ($signed({2'b0, quo_q}) - Q12One);
          state_q <= T_CHK;
        end
        T_CHK: begin
          if (a24_q >= A24Limit) begin
            done_q  <= 1'b1;
            skip_q  <= 1'b1;
            state_q <= T_IDLE;
          end else begin
            xl_q    <= x_s * l_s;
            state_q <= T_Z;
          end
        end
        T_Z: begin
          lo_q    <= ExpTbl[k_lo];
          hi_q    <= ExpTbl[k_hi];
          frac_q  <= z[FracW-1:0];
          n_q     <= z[ZW-1:ZFracW];
          state_q <= T_MUL;
        end
        T_MUL: begin
          pm_q    <= (hi_q - lo_q) * frac_q;
          state_q <= T_RND;
        end
        T_RND: begin
          term_q  <= term_d;
          done_q  <= 1'b1;
          skip_q  <= 1'b0;
          state_q <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.skip = skip_q;
  assign rsp_o.term = term_q;

endmodule

`default_nettype wire

/* rtl/gaussian_blob_grid_splat_core.sv */
// Top level of the blobby density grid splat core: sequencer, window walk
// and result register. Depends on gbs_pkg, gbs_grid_mem and gbs_term.
//
// The grid lives in one memory of GRID_SIDE^3 words of Q16.16 density. After
// reset the core runs a clearing pass over all GRID_SIDE^3 words (262144 at
// the default size) with in_stall_o high; configuration writes are taken
// during it. A clear request runs the same pass and then returns one
// response. An in-range read registers the memory word in S_RD. A splat
// request walks its clipped window one voxel at a time; the cost of a voxel
// is set by the one-bit-per-cycle quotient of d^2/r^2 in the term unit plus
// the exp stages and the read-modify-write of the memory. A voxel past the
// cutoff skips the exp stages and the write, and one whose quotient
// overflows also skips the division. One request is worked at a time; a
// finished response waits in the output register.
`default_nettype none

module gaussian_blob_grid_splat_core
  import gbs_pkg::*;
#(
  parameter int GRID_SIDE      = GRID_SIDE_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_req_t               in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_rsp_t                   out_rsp_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int Depth = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WIN, S_SQ, S_SUM, S_TERM, S_WR, S_RD, S_DONE
  } state_e;

  typedef struct packed {
    logic             empty;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } win_t;

  // Effective extent: the register value, capped at the grid side.
  function automatic logic [EXT_W-1:0] eff_ext(logic [EXT_W-1:0] v);
    if (int'(v) > GRID_SIDE) return EXT_W'(GRID_SIDE);
    return v;
  endfunction

  // Window along one axis around the rounded centre.
  function automatic win_t axis_win(logic [CENTRE_W-1:0] c, logic [EXT_W-1:0] ext,
                                    logic [HW_W-1:0] hw);
    logic signed [CENTRE_W:0] sum;
    logic signed [WIN_W-1:0]  ic;
    logic signed [WIN_W-1:0]  lo_s;
    logic signed [WIN_W-1:0]  hi_s;
    logic signed [WIN_W-1:0]  ext_s;
    win_t                     w;
    sum   = $signed({c[CENTRE_W-1], c}) + $signed({1'b0, HALF_VOXEL});
    ic    = WIN_W'(sum >>> FRAC_W);
    ext_s = $signed({{(WIN_W-EXT_W){1'b0}}, ext});
    lo_s  = ic - $signed({{(WIN_W-HW_W){1'b0}}, hw});
    hi_s  = ic + $signed({{(WIN_W-HW_W){1'b0}}, hw});
    if (lo_s < 0) lo_s = '0;
    if (hi_s > ext_s) hi_s = ext_s;
    w.empty = (lo_s >= hi_s);
    w.lo    = lo_s[IDX_W-1:0];
    w.hi    = hi_s[IDX_W-1:0];
    return w;
  endfunction

  // Offset of voxel i from the centre, Q.12; the voxel sits at i - 0.5.
  function automatic logic signed [DIST_W-1:0] voxel_offset(logic [IDX_W-1:0] i,
                                                            logic [CENTRE_W-1:0] c);
    return $signed({{(DIST_W-IDX_W-FRAC_W){1'b0}}, i, {FRAC_W{1'b0}}})
         - $signed({{(DIST_W-CENTRE_W){1'b0}}, HALF_VOXEL})
         - $signed({{(DIST_W-CENTRE_W){c[CENTRE_W-1]}}, c});
  endfunction

  function automatic logic [AddrW-1:0] vox_addr(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y,
                                                logic [IDX_W-1:0] z);
    logic [31:0] a;
    a = 32'(x) * 32'(GRID_SIDE * GRID_SIDE) + 32'(y) * 32'(GRID_SIDE) + 32'(z);
    return a[AddrW-1:0];
  endfunction

  // Registers.
  state_e              state_q;
  logic [AddrW-1:0]    clr_addr_q;
  logic                clr_item_q;
  logic [BLOB_W-1:0]   blob_q;
  logic [HW_W-1:0]     hw_q;
  logic [EXT_W-1:0]    ext_x_q;
  logic [EXT_W-1:0]    ext_y_q;
  logic [EXT_W-1:0]    ext_z_q;
  in_req_t             req_q;
  logic [R2_W-1:0]     r2_q;
  logic [IDX_W-1:0]    lo_x_q, hi_x_q, lo_y_q, hi_y_q, lo_z_q, hi_z_q;
  logic [IDX_W-1:0]    ix_q, iy_q, iz_q;
  logic [D2_W-1:0]     sqx_q, sqy_q, sqz_q;
  logic [AddrW-1:0]    addr_q;
  logic [VALUE_W-1:0]  res_value_q;
  logic                res_out_q;
  logic                res_sat_q;
  logic                out_valid_q;
  out_rsp_t            out_rsp_q;

  // Combinational signals.
  logic                  in_accept;
  logic [EXT_W-1:0]      ext_x, ext_y, ext_z;
  win_t                  win_x, win_y, win_z;
  logic signed [DIST_W-1:0]   dx, dy, dz;
  logic signed [2*DIST_W-1:0] px, py, pz;
  logic                  rd_outside;
  logic [AddrW-1:0]      rd_addr;
  logic [IDX_W-1:0]      ix_inc, iy_inc, iz_inc;
  logic                  x_last, y_last, z_last;
  logic [VALUE_W:0]      acc_sum;
  logic                  acc_ovf;
  logic                  out_load;
  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [VALUE_W-1:0]    mem_wdata;
  logic                  mem_re;
  logic [AddrW-1:0]      mem_raddr;
  logic [VALUE_W-1:0]    mem_rdata;
  term_req_t             term_req;
  term_rsp_t             term_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign ext_x = eff_ext(ext_x_q);
  assign ext_y = eff_ext(ext_y_q);
  assign ext_z = eff_ext(ext_z_q);

  assign win_x = axis_win(req_q.centre_x, ext_x, hw_q);
  assign win_y = axis_win(req_q.centre_y, ext_y, hw_q);
  assign win_z = axis_win(req_q.centre_z, ext_z, hw_q);

  // Squared offsets of the current voxel.
  assign dx = voxel_offset(ix_q, req_q.centre_x);
  assign dy = voxel_offset(iy_q, req_q.centre_y);
  assign dz = voxel_offset(iz_q, req_q.centre_z);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // Read request checks.
  assign rd_outside = ({1'b0, in_req_i.voxel_x} >= ext_x) ||
                      ({1'b0, in_req_i.voxel_y} >= ext_y) ||
                      ({1'b0, in_req_i.voxel_z} >= ext_z);
  assign rd_addr = vox_addr({1'b0, in_req_i.voxel_x}, {1'b0, in_req_i.voxel_y},
                            {1'b0, in_req_i.voxel_z});

  // Window walk, z innermost.
  assign ix_inc = ix_q + 1'b1;
  assign iy_inc = iy_q + 1'b1;
  assign iz_inc = iz_q + 1'b1;
  assign x_last = (ix_inc == hi_x_q);
  assign y_last = (iy_inc == hi_y_q);
  assign z_last = (iz_inc == hi_z_q);

  // Saturating accumulate.
  assign acc_sum = {1'b0, mem_rdata} + {1'b0, term_rsp.term};
  assign acc_ovf = acc_sum[VALUE_W];

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = acc_ovf ? {VALUE_W{1'b1}} : acc_sum[VALUE_W-1:0];
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (state_q == S_WR) begin
      mem_we = 1'b1;
    end
    if (state_q == S_SUM) begin
      mem_re = 1'b1;
    end else if (in_accept && in_req_i.func == FUNC_READ) begin
      mem_re    = 1'b1;
      mem_raddr = rd_addr;
    end
  end

  // Term unit request.
  assign term_req.start = (state_q == S_SUM);
  assign term_req.d2    = sqx_q + sqy_q + sqz_q;
  assign term_req.r2    = r2_q;
  assign term_req.t     = -blob_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blob_q  <= BLOB_RESET;
      hw_q    <= HW_RESET;
      ext_x_q <= EXT_RESET;
      ext_y_q <= EXT_RESET;
      ext_z_q <= EXT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLOB:       blob_q  <= cfg_data_i[BLOB_W-1] ? cfg_data_i[BLOB_W-1:0]
                                                        : BLOB_RESET;
        CFG_HALF_WIDTH: hw_q    <= cfg_data_i[HW_W-1:0];
        CFG_EXT_X:      ext_x_q <= cfg_data_i[EXT_W-1:0];
        CFG_EXT_Y:      ext_y_q <= cfg_data_i[EXT_W-1:0];
        CFG_EXT_Z:      ext_z_q <= cfg_data_i[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_addr_q  <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q) inside
        S_CLR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AddrW'(Depth - 1)) begin
            state_q <= clr_item_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            req_q       <= in_req_i;
            res_value_q <= '0;
            res_out_q   <= 1'b0;
            res_sat_q   <= 1'b0;
            r2_q        <= (in_req_i.atom_radius == '0) ? R2_W'(1)
                         : R2_W'(in_req_i.atom_radius) * R2_W'(in_req_i.atom_radius);
            case (in_req_i.func)
              FUNC_CLEAR: begin
                clr_addr_q <= '0;
                clr_item_q <= 1'b1;
                state_q    <= S_CLR;
              end
              FUNC_SPLAT: state_q <= S_WIN;
              FUNC_READ: begin
                if (rd_outside) begin
                  res_out_q <= 1'b1;
                  state_q   <= S_DONE;
                end else begin
                  state_q <= S_RD;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_WIN: begin
          if (win_x.empty || win_y.empty || win_z.empty) begin
            state_q <= S_DONE;
          end else begin
            lo_x_q  <= win_x.lo;
            hi_x_q  <= win_x.hi;
            lo_y_q  <= win_y.lo;
            hi_y_q  <= win_y.hi;
            lo_z_q  <= win_z.lo;
            hi_z_q  <= win_z.hi;
            ix_q    <= win_x.lo;
            iy_q    <= win_y.lo;
            iz_q    <= win_z.lo;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sqx_q   <= px;
          sqy_q   <= py;
          sqz_q   <= pz;
          addr_q  <= vox_addr(ix_q, iy_q, iz_q);
          state_q <= S_SUM;
        end
        S_SUM: state_q <= S_TERM;
        S_TERM, S_WR: begin
          if (state_q == S_WR || (term_rsp.done && term_rsp.skip)) begin
            if (state_q == S_WR && acc_ovf) res_sat_q <= 1'b1;
            // Step to the next voxel of the window.
            if (!z_last) begin
              iz_q <= iz_inc;
            end else begin
              iz_q <= lo_z_q;
              if (!y_last) begin
                iy_q <= iy_inc;
              end else begin
                iy_q <= lo_y_q;
                ix_q <= ix_inc;
              end
            end
            state_q <= (z_last && y_last && x_last) ? S_DONE : S_SQ;
          end else if (term_rsp.done) begin
            state_q <= S_WR;
          end
        end
        S_RD: begin
          res_value_q <= mem_rdata;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_rsp_q.field_value   <= res_value_q;
            out_rsp_q.index_outside <= res_out_q;
            out_rsp_q.saturated     <= res_sat_q;
            clr_item_q              <= 1'b0;
            state_q                 <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  gbs_grid_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  gbs_term #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (term_req),
    .rsp_o  (term_rsp)
  );

endmodule

`default_nettype wire

/* rtl/gbs_checker.sv */
// Port-level checks for the splat core, bound to its top level.
// Depends on gbs_pkg and gaussian_blob_grid_splat_core.
`default_nettype none

module gbs_checker
  import gbs_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire out_rsp_t out_rsp_o
);

  // A stalled response holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // An out-of-range read carries neither a value nor a saturation flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.index_outside |->
      out_rsp_o.field_value == '0 && !out_rsp_o.saturated)
    else $error("outside read with payload");

  // Requests are worked one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

endmodule

bind gaussian_blob_grid_splat_core gbs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

/* tb/sv/gaussian_blob_grid_splat_core_test.sv */
// Self-checking testbench for gaussian_blob_grid_splat_core: random and directed
// clear, splat and read requests checked against a scoreboard with its own grid.
// Depends on gbs_pkg and the core RTL.
`timescale 1ns / 1ps

module gaussian_blob_grid_splat_core_test
  import gbs_pkg::*;
();

  localparam int SIDE = 64;
  localparam int TBL_BITS = 10;
  localparam int TBL_LEN = 1 << TBL_BITS;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam longint BLOB_DEFAULT = -10240;
  localparam longint LOG2E = 1549082005;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int REQ_W = $bits(in_req_t);

  // Scoreboard: keeps its own copy of the grid and the registers and
  // predicts the response of every accepted request.
  class density_scoreboard;
    bit [31:0] grid [SIDE*SIDE*SIDE];
    longint unsigned pow2_tbl [TBL_LEN+1];
    longint blob;
    int half_width;
    int extent [3];
    out_rsp_t expected_q [$];
    int errors;
    int n_splat, n_read, n_sat, n_outside;

    function new();
      longint unsigned roots [TBL_BITS+1];
      longint unsigned acc;
      roots[0] = 64'h8000_0000;
      for (int j = 1; j <= TBL_BITS; j++) roots[j] = int_sqrt(roots[j-1] << 30);
      for (int k = 0; k < TBL_LEN; k++) begin
        acc = 64'h4000_0000;
        for (int b = 0; b < TBL_BITS; b++)
          if ((k >> b) & 1) acc = (acc * roots[TBL_BITS-b] + 64'h2000_0000) >> 30;
        pow2_tbl[k] = acc;
      end
      pow2_tbl[TBL_LEN] = 64'h8000_0000;
      blob = BLOB_DEFAULT;
      half_width = 10;
      foreach (extent[a]) extent[a] = 64;
      foreach (grid[i]) grid[i] = '0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      longint b;
      case (idx)
        CFG_BLOB: begin
          b = $signed(data);
          blob = (b >= 0) ? BLOB_DEFAULT : b;
        end
        CFG_HALF_WIDTH: half_width = data[5:0];
        CFG_EXT_X: extent[0] = (data[6:0] > SIDE) ? SIDE : data[6:0];
        CFG_EXT_Y: extent[1] = (data[6:0] > SIDE) ? SIDE : data[6:0];
        CFG_EXT_Z: extent[2] = (data[6:0] > SIDE) ? SIDE : data[6:0];
        default: ;
      endcase
    endfunction

    // exp(x/2^24) in Q16.16 through a base-2 table with interpolation.
    function longint unsigned exp_q16(longint x24);
      longint z, n, sh;
      longint unsigned f, k, rem, lo, hi, m;
      z = (x24 * LOG2E + (64'sd1 << 29)) >>> 30;
      n = z >>> 24;
      f = z - n * (64'sd1 << 24);
      k = (f >> (24 - TBL_BITS)) & (TBL_LEN - 1);
      rem = f & ((64'd1 << (24 - TBL_BITS)) - 1);
      lo = pow2_tbl[k];
      hi = pow2_tbl[k+1];
      m = lo + (((hi - lo) * rem) >> (24 - TBL_BITS));
      sh = 14 - n;
      if (sh >= 63) return 0;
      if (sh < 1) sh = 1;
      return (m + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Adds one atom to the grid; returns 1 if any voxel clamped.
    function bit splat_atom(in_req_t req);
      longint c [3], lo [3], hi [3], ic, a24, d;
      longint unsigned rad, r2, d2, q12, term, sum;
      bit sat;
      int idx;
      sat = 0;
      c[0] = $signed(req.centre_x);
      c[1] = $signed(req.centre_y);
      c[2] = $signed(req.centre_z);
      rad = req.atom_radius;
      if (rad == 0) rad = 1;
      r2 = rad * rad;
      for (int a = 0; a < 3; a++) begin
        ic = ((c[a] + 2048 + (64'sd1 << 21)) >>> 12) - 512;
        lo[a] = (ic - half_width < 0) ? 0 : ic - half_width;
        hi[a] = (ic + half_width > extent[a]) ? extent[a] : ic + half_width;
      end
      for (longint i = lo[0]; i < hi[0]; i++)
        for (longint j = lo[1]; j < hi[1]; j++)
          for (longint k = lo[2]; k < hi[2]; k++) begin
            d = i * 4096 - 2048 - c[0];
            d2 = d * d;
            d = j * 4096 - 2048 - c[1];
            d2 = d2 + d * d;
            d = k * 4096 - 2048 - c[2];
            d2 = d2 + d * d;
            q12 = (d2 << 12) / r2;
            if (q12 > (64'd1 << 32)) q12 = 64'd1 << 32;
            a24 = (-blob) * (longint'(q12) - 4096);
            if (a24 < (64'sd16 << 24)) begin
              term = exp_q16(-a24);
              idx = (int'(i) * SIDE + int'(j)) * SIDE + int'(k);
              sum = grid[idx] + term;
              if (sum > 64'hFFFF_FFFF) begin
                sum = 64'hFFFF_FFFF;
                sat = 1;
              end
              grid[idx] = sum[31:0];
            end
          end
      return sat;
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t rsp;
      rsp = '0;
      case (req.func)
        FUNC_CLEAR: foreach (grid[i]) grid[i] = '0;
        FUNC_SPLAT: begin
          rsp.saturated = splat_atom(req);
          n_splat++;
          n_sat += rsp.saturated;
        end
        FUNC_READ: begin
          n_read++;
          if (req.voxel_x >= extent[0] || req.voxel_y >= extent[1] ||
              req.voxel_z >= extent[2]) begin
            rsp.index_outside = 1'b1;
            n_outside++;
          end else begin
            rsp.field_value = grid[(int'(req.voxel_x) * SIDE + int'(req.voxel_y)) * SIDE +
                                   int'(req.voxel_z)];
          end
        end
        default: ;
      endcase
      expected_q.push_back(rsp);
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: response with none expected: %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.field_value !== want.field_value) begin
        $display("%0t: field_value expected %h actual %h", $time, want.field_value,
                 got.field_value);
        errors++;
      end
      if (got.index_outside !== want.index_outside) begin
        $display("%0t: index_outside expected %b actual %b", $time, want.index_outside,
                 got.index_outside);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_req_t in_req_i;
  out_rsp_t out_rsp_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  density_scoreboard sb;
  int send_idle_pct, stall_pct;
  int cycles;

  gaussian_blob_grid_splat_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watch both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_request(in_req_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
  end

  // Receiver stalls at random according to the current phase.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int blob_v, int hw, int ex, int ey, int ez);
    write_reg(CFG_BLOB, blob_v[15:0]);
    write_reg(CFG_HALF_WIDTH, hw[15:0]);
    write_reg(CFG_EXT_X, ex[15:0]);
    write_reg(CFG_EXT_Y, ey[15:0]);
    write_reg(CFG_EXT_Z, ez[15:0]);
  endtask

  // Presents one request and returns just after the edge that took it.
  task automatic send_request(in_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic in_req_t make_req(logic [1:0] f, int cx, int cy, int cz, int rad,
                                       int vx, int vy, int vz);
    in_req_t r;
    r.func = f;
    r.centre_x = cx[21:0];
    r.centre_y = cy[21:0];
    r.centre_z = cz[21:0];
    r.atom_radius = rad[15:0];
    r.voxel_x = vx[5:0];
    r.voxel_y = vy[5:0];
    r.voxel_z = vz[5:0];
    return r;
  endfunction

  // Mostly splats near the used grid and reads inside it, with some noise.
  function automatic in_req_t random_req();
    in_req_t r;
    int sel;
    r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 50) begin
      r.func = FUNC_SPLAT;
      if ($urandom_range(9) != 0) begin
        r.centre_x = 22'($urandom_range(sb.extent[0] * 4096 + 4096) - 4096);
        r.centre_y = 22'($urandom_range(sb.extent[1] * 4096 + 4096) - 4096);
        r.centre_z = 22'($urandom_range(sb.extent[2] * 4096 + 4096) - 4096);
        r.atom_radius = 16'($urandom_range(20000, 1));
      end
    end else if (sel < 92) begin
      r.func = FUNC_READ;
      if ($urandom_range(3) != 0) begin
        r.voxel_x = 6'($urandom_range(sb.extent[0] - 1));
        r.voxel_y = 6'($urandom_range(sb.extent[1] - 1));
        r.voxel_z = 6'($urandom_range(sb.extent[2] - 1));
      end
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  initial begin
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BLOB;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests; registers go in while the start-up clear runs.
    set_config(-10240, 2, 64, 64, 64);
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 63, 63, 63));
    send_request(make_req(FUNC_SPLAT, 5 * 4096, 5 * 4096, 5 * 4096, 2 * 4096, 0, 0, 0));
    // Centre exactly on a half rounds up.
    send_request(make_req(FUNC_SPLAT, 3 * 4096 + 2048, 4096, 2048, 4096, 0, 0, 0));
    // Zero radius is taken as the smallest radius.
    send_request(make_req(FUNC_SPLAT, 20 * 4096, 20 * 4096, 20 * 4096, 0, 0, 0, 0));
    send_request(make_req(FUNC_SPLAT, 10 * 4096, 10 * 4096, 10 * 4096, 65535, 0, 0, 0));
    // Atoms far outside either end of the grid touch nothing.
    send_request(make_req(FUNC_SPLAT, -2097152, -2097152, -2097152, 65535, 0, 0, 0));
    send_request(make_req(FUNC_SPLAT, 2097151, 2097151, 2097151, 65535, 0, 0, 0));
    send_request(make_req(FUNC_SPLAT, -4096, 62 * 4096, -2048, 3 * 4096, 0, 0, 0));
    send_request(make_req(FUNC_UNUSED, -1, -1, -1, 65535, 63, 63, 63));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 5, 5, 5));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 4, 5, 6));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 10, 10, 10));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 20, 20, 19));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 0, 63, 0));
    send_request(make_req(FUNC_CLEAR, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 5, 5, 5));
    wait_idle();

    // Extreme registers: sharpest blob, half width 32 over a tiny grid.
    set_config(-32768, 32, 2, 3, 1);
    send_request(make_req(FUNC_SPLAT, 4096, 0, -2048, 4096, 0, 0, 0));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 1, 2, 0));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 2, 0, 0));
    wait_idle();
    // A non-negative blobbyness falls back to its default; zero width is empty.
    set_config(32767, 0, 127, 64, 64);
    send_request(make_req(FUNC_SPLAT, 4096, 4096, 4096, 4096, 0, 0, 0));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 63, 63, 63));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 1, 1, 1));
    wait_idle();

    // Random phases with different idling patterns.
    for (int phase = 0; phase < 4; phase++) begin
      set_config(-int'($urandom_range(32768, 1)), $urandom_range(3),
                 $urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(64, 1));
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 34 : 83) : 0;
      stall_pct = (phase == 2) ? 83 : ((phase == 3) ? 34 : 0);
      for (int n = 0; n < 15; n++) begin
        send_request(random_req());
        // Hold the sender until the block has drained once.
        if (phase == 1 && n == 10) wait_idle();
      end
      wait_idle();
    end

    // Repeated strong atoms on one voxel drive it into saturation.
    set_config(-32768, 1, 1, 1, 1);
    send_idle_pct = 34;
    stall_pct = 34;
    for (int n = 0; n < 26; n++)
      send_request(make_req(FUNC_SPLAT, -2048 + $urandom_range(600), -2048, -2048,
                            $urandom_range(65535, 30000), 0, 0, 0));
    send_request(make_req(FUNC_READ, 0, 0, 0, 1, 0, 0, 0));
    wait_idle();
    repeat (100) @(posedge clk_i);

    $display("Covered %0d splats (%0d saturating) and %0d reads (%0d outside the grid).",
             sb.n_splat, sb.n_sat, sb.n_read, sb.n_outside);
    $display("Registers swept through defaults, extremes and random settings.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.errors, sb.expected_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gbs_pkg.sv
rtl/gbs_grid_mem.sv
rtl/gbs_term.sv
rtl/gaussian_blob_grid_splat_core.sv
rtl/gbs_checker.sv
tb/sv/gaussian_blob_grid_splat_core_test.sv
